// ----- hw/rtl/gps_pkg.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll sequencer package
// Shared payload types, configuration bundle, codes and lane helper.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int AXES       = 4;
  localparam int AXIS_LIMIT = (AXES < 4) ? AXES : 4;

  // Input commands.
  localparam logic [1:0] CMD_ALARM  = 2'd0;
  localparam logic [1:0] CMD_DONE   = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_WRITE    = 2'd0;
  localparam logic [1:0] KIND_READ     = 2'd1;
  localparam logic [1:0] KIND_SCHEDULE = 2'd2;
  localparam logic [1:0] KIND_REPORT   = 2'd3;

  localparam logic [7:0] MOD_GPIO      = 8'd1;
  localparam logic [7:0] MOD_ADC       = 8'd9;
  localparam logic [7:0] FUNC_GPIO_RD  = 8'd4;
  localparam logic [7:0] FUNC_ADC_BASE = 8'd7;

  localparam logic [2:0] LEN_GPIO = 3'd4;
  localparam logic [2:0] LEN_ADC  = 3'd2;

  localparam logic [8:0] DELAY_GPIO_REQ = 9'd250;
  localparam logic [8:0] DELAY_SHORT    = 9'd100;
  localparam logic [8:0] DELAY_ADC_REQ  = 9'd500;

  localparam logic [4:0]  LANE_UNUSED = 5'd31;
  localparam logic [15:0] AXIS_MAX    = 16'hFFFF;
  localparam logic [15:0] SAMPLE_INIT = 16'h01FF;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_BUTTON_PINS   = 3'd0;
  localparam logic [2:0] REG_AXIS_CHANNELS = 3'd1;
  localparam logic [2:0] REG_FULL_SCALE    = 3'd2;
  localparam logic [2:0] REG_AXIS_INVERT   = 3'd3;
  localparam logic [2:0] REG_DEVICE_ADDR   = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        write_acked;
    logic [31:0] read_data;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [6:0]  bus_address;
    logic [7:0]  bus_module;
    logic [7:0]  bus_function;
    logic [2:0]  read_length;
    logic [8:0]  next_delay_us;
    logic [3:0]  buttons;
    logic [15:0] axis_0;
    logic [15:0] axis_1;
    logic [15:0] axis_2;
    logic [15:0] axis_3;
  } res_item_t;

  typedef struct packed {
    logic [19:0] button_pins;
    logic [19:0] axis_channels;
    logic [15:0] axis_full_scale;
    logic [3:0]  axis_invert;
    logic [6:0]  device_address;
  } cfg_t;

  function automatic logic [4:0] lane(input logic [19:0] word, input logic [1:0] idx);
    logic [4:0] v;
    case (idx)
      2'd0:    v = word[4:0];
      2'd1:    v = word[9:5];
      2'd2:    v = word[14:10];
      default: v = word[19:15];
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/gamepad_poll_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll sequencer core
// Issues the poll cycle of a gamepad bridge and builds joystick reports.
//
// Commands arrive on the cmd channel (cmd_valid/cmd_stall/cmd_item) and bus
// actions, alarm schedules and reports leave on the res channel
// (res_valid/res_stall/res_item). A transaction moves on a rising edge with
// valid high and stall low. One command is handled at a time: cmd_stall is
// low only while the block is idle, but a finished result may still wait in
// the output register while the next command is taken.
// Alarms and completions give at most one result; the command is registered,
// then decoded in the execute state, which loads the result into the output
// register once it is free. An update request in the rest phase runs four
// bit-serial divisions on the shared serial divider (one per axis), then
// gives the report followed by the first command write.
// A stalled receiver holds the output register, and the block waits for it
// before it writes the next result. Synchronous reset empties the output,
// returns to idle, sets the phase to the GPIO read and restores samples.
// ----------------------------------------------------------------------------
module gamepad_poll_sequencer_core import gps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_item_t   cmd_item,
  output logic        res_valid,
  input  logic        res_stall,
  output res_item_t   res_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    PH_GPIO_REQ,
    PH_GPIO_READ,
    PH_ADC_REQ,
    PH_ADC_READ,
    PH_REST
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LAUNCH,
    S_WAIT,
    S_REPORT,
    S_RESTART
  } state_t;

  cfg_t        cfg;
  state_t      state;
  phase_t      phase;
  logic [1:0]  axis_index;
  logic [31:0] pin_word;
  logic [15:0] samples [4];
  logic [15:0] axes [4];
  logic [1:0]  k;
  cmd_item_t   item;

  logic        slot_free;
  logic        res_load;
  logic        ex_has;
  logic        ex_report;
  res_item_t   ex_res;
  phase_t      phase_next;
  logic [1:0]  axis_index_next;
  logic        pin_we;
  logic        smp_we;
  logic [2:0]  nxt;
  logic        cycle_end;

  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;
  logic [31:0] dividend;
  logic [15:0] divisor;
  logic [15:0] axis_val;
  logic [3:0]  buttons;
  res_item_t   rep_res;
  res_item_t   wr_res;

  gps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign divisor   = (cfg.axis_full_scale == 16'd0) ? 16'd1 : cfg.axis_full_scale;
  // sample * 65535 as (sample << 16) - sample.
  assign dividend  = {samples[k], 16'd0} - {16'd0, samples[k]};
  assign div_start = (state == S_LAUNCH);

  gps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign axis_val  = cfg.axis_invert[k] ? ~div_q : div_q;
  assign cmd_stall = (state != S_IDLE);
  assign slot_free = !res_valid || !res_stall;
  assign res_load  = slot_free && (((state == S_EXEC) && !ex_report && ex_has) ||
                                   (state == S_REPORT) || (state == S_RESTART));

  assign nxt       = {1'b0, axis_index} + 3'd1;
  assign cycle_end = (nxt >= 3'(AXIS_LIMIT)) ||
                     (lane(cfg.axis_channels, nxt[1:0]) == LANE_UNUSED);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      buttons[i] = ~pin_word[lane(cfg.button_pins, 2'(i))];
    end
  end

  always_comb begin
    rep_res         = '0;
    rep_res.kind    = KIND_REPORT;
    rep_res.buttons = buttons;
    rep_res.axis_0  = axes[0];
    rep_res.axis_1  = axes[1];
    rep_res.axis_2  = axes[2];
    rep_res.axis_3  = axes[3];

    wr_res              = '0;
    wr_res.kind         = KIND_WRITE;
    wr_res.last         = 1'b1;
    wr_res.bus_address  = cfg.device_address;
    wr_res.bus_module   = MOD_GPIO;
    wr_res.bus_function = FUNC_GPIO_RD;
  end

  // Decode of the held command: its result, if any, and the state it leaves.
  always_comb begin
    ex_has          = 1'b0;
    ex_report       = 1'b0;
    ex_res          = '0;
    ex_res.last     = 1'b1;
    phase_next      = phase;
    axis_index_next = axis_index;
    pin_we          = 1'b0;
    smp_we          = 1'b0;
    case (item.cmd)
      CMD_ALARM: begin
        ex_res.bus_address = cfg.device_address;
        case (phase)
          PH_GPIO_REQ: begin
            ex_has              = 1'b1;
            ex_res.kind         = KIND_WRITE;
            ex_res.bus_module   = MOD_GPIO;
            ex_res.bus_function = FUNC_GPIO_RD;
          end
          PH_ADC_REQ: begin
            ex_has              = 1'b1;
            ex_res.kind         = KIND_WRITE;
            ex_res.bus_module   = MOD_ADC;
            ex_res.bus_function = FUNC_ADC_BASE +
                                  {3'd0, lane(cfg.axis_channels, axis_index)};
          end
          PH_GPIO_READ: begin
            ex_has             = 1'b1;
            ex_res.kind        = KIND_READ;
            ex_res.read_length = LEN_GPIO;
          end
          PH_ADC_READ: begin
            ex_has             = 1'b1;
            ex_res.kind        = KIND_READ;
            ex_res.read_length = LEN_ADC;
          end
          default: ;
        endcase
      end
      CMD_DONE: begin
        ex_res.kind = KIND_SCHEDULE;
        case (phase)
          PH_GPIO_REQ: begin
            ex_has               = 1'b1;
            ex_res.next_delay_us = DELAY_GPIO_REQ;
            if (item.write_acked) phase_next = PH_GPIO_READ;
          end
          PH_GPIO_READ: begin
            ex_has               = 1'b1;
            ex_res.next_delay_us = DELAY_SHORT;
            pin_we               = 1'b1;
            phase_next           = PH_ADC_REQ;
          end
          PH_ADC_REQ: begin
            ex_has               = 1'b1;
            ex_res.next_delay_us = DELAY_ADC_REQ;
            if (item.write_acked) phase_next = PH_ADC_READ;
          end
          PH_ADC_READ: begin
            smp_we = 1'b1;
            if (cycle_end) begin
              axis_index_next = 2'd0;
              phase_next      = PH_REST;
            end else begin
              ex_has               = 1'b1;
              ex_res.next_delay_us = DELAY_SHORT;
              axis_index_next      = nxt[1:0];
              phase_next           = PH_ADC_REQ;
            end
          end
          default: ;
        endcase
      end
      CMD_UPDATE: begin
        ex_report = (phase == PH_REST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      phase      <= PH_GPIO_READ;
      axis_index <= 2'd0;
      pin_word   <= 32'hFFFF_FFFF;
      k          <= 2'd0;
      for (int i = 0; i < 4; i++) begin
        samples[i] <= SAMPLE_INIT;
      end
    end else begin
      res_valid <= res_load || (res_valid && res_stall);
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            item  <= cmd_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ex_report) begin
            k     <= 2'd0;
            state <= S_LAUNCH;
          end else if (!ex_has || slot_free) begin
            phase      <= phase_next;
            axis_index <= axis_index_next;
            if (pin_we) pin_word <= item.read_data;
            if (smp_we) samples[axis_index] <= item.read_data[15:0];
            if (ex_has) begin
              res_item <= ex_res;
            end
            state <= S_IDLE;
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            axes[k] <= axis_val;
            if (k == 2'd3) begin
              state <= S_REPORT;
            end else begin
              k     <= k + 2'd1;
              state <= S_LAUNCH;
            end
          end
        end
        S_REPORT: begin
          if (slot_free) begin
            res_item <= rep_res;
            phase    <= PH_GPIO_REQ;
            state    <= S_RESTART;
          end
        end
        S_RESTART: begin
          if (slot_free) begin
            res_item <= wr_res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gps_cfg.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll sequencer configuration registers
// APB-style register file holding pins, channels, scale, invert and address.
// ----------------------------------------------------------------------------
module gps_cfg import gps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_pins     <= 20'h00000;
      cfg.axis_channels   <= 20'hFFFFF;
      cfg.axis_full_scale <= 16'd1;
      cfg.axis_invert     <= 4'd0;
      cfg.device_address  <= 7'h50;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BUTTON_PINS:   cfg.button_pins     <= pwdata[19:0];
        REG_AXIS_CHANNELS: cfg.axis_channels   <= pwdata[19:0];
        REG_FULL_SCALE:    cfg.axis_full_scale <= pwdata[15:0];
        REG_AXIS_INVERT:   cfg.axis_invert     <= pwdata[3:0];
        REG_DEVICE_ADDR:   cfg.device_address  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BUTTON_PINS:   prdata = {12'd0, cfg.button_pins};
      REG_AXIS_CHANNELS: prdata = {12'd0, cfg.axis_channels};
      REG_FULL_SCALE:    prdata = {16'd0, cfg.axis_full_scale};
      REG_AXIS_INVERT:   prdata = {28'd0, cfg.axis_invert};
      REG_DEVICE_ADDR:   prdata = {25'd0, cfg.device_address};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/gps_div.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll sequencer axis divider
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor, with the
// quotient saturated to 16 bits. One dividend bit enters per cycle.
// ----------------------------------------------------------------------------
module gps_div import gps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [31:0] dvd;
  logic [15:0] rem;
  logic [15:0] quo;
  logic        ovf;
  logic [4:0]  cnt;
  logic        busy;

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        fits;

  assign rem_sh  = {rem, dvd[31]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign fits    = rem_sh >= {1'b0, divisor};

  assign quotient = ovf ? AXIS_MAX : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Any quotient bit pushed past bit 15 means the result saturates.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= 16'd0;
      quo <= 16'd0;
      ovf <= 1'b0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      rem <= fits ? rem_sub[15:0] : rem_sh[15:0];
      quo <= {quo[14:0], fits};
      ovf <= ovf | quo[15];
    end
  end

endmodule

// ----- tb/tb_gamepad_poll_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// Gamepad poll sequencer core testbench
// Drives alarm, completion and update commands through the poll cycle under
// several register settings, predicts every bus action, alarm schedule and
// joystick report, and checks each result transaction field by field.
// ----------------------------------------------------------------------------
module tb_gamepad_poll_sequencer_core;
  import gps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED    = 2'd3;
  localparam int         SETTLE_CYCLES = 200;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         PRINT_LIMIT   = 40;

  typedef enum logic [2:0] {
    PH_GPIO_REQ, PH_GPIO_READ, PH_ADC_REQ, PH_ADC_READ, PH_REST
  } poll_phase_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        cmd_valid;
  logic        cmd_stall;
  cmd_item_t   cmd_item;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_item_t   res_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: registers and poll state.
  cfg_t        shadow_cfg;
  poll_phase_e poll_phase;
  logic [1:0]  axis_idx;
  logic [31:0] pin_word;
  logic [15:0] axis_samples [0:3];
  bit          action_pending;
  bit          cmd_effective;

  res_item_t   awaited_actions [$];
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          stall_run = 0;
  int          stall_mode = 0;

  gamepad_poll_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern: runs of free flow, random, heavy and periodic stalls.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 1) == 1);
      2: res_stall <= ($urandom_range(0, 7) != 0);
      default: res_stall <= (stall_run[3:0] < 4'd5);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic bit bus_action(output res_item_t r);
    r = '0;
    r.bus_address = shadow_cfg.device_address;
    case (poll_phase)
      PH_GPIO_REQ: begin
        r.kind         = KIND_WRITE;
        r.bus_module   = MOD_GPIO;
        r.bus_function = FUNC_GPIO_RD;
        return 1'b1;
      end
      PH_ADC_REQ: begin
        r.kind         = KIND_WRITE;
        r.bus_module   = MOD_ADC;
        r.bus_function = FUNC_ADC_BASE + {3'd0, shadow_cfg.axis_channels[5*axis_idx +: 5]};
        return 1'b1;
      end
      PH_GPIO_READ: begin
        r.kind        = KIND_READ;
        r.read_length = LEN_GPIO;
        return 1'b1;
      end
      PH_ADC_READ: begin
        r.kind        = KIND_READ;
        r.read_length = LEN_ADC;
        return 1'b1;
      end
      default: begin
        r = '0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic res_item_t alarm_schedule(input logic [8:0] alarm_gap);
    res_item_t r;
    r               = '0;
    r.kind          = KIND_SCHEDULE;
    r.next_delay_us = alarm_gap;
    return r;
  endfunction

  function automatic res_item_t joystick_report();
    res_item_t   r;
    logic [15:0] scaled [0:3];
    logic [31:0] fs;
    logic [31:0] q;
    r      = '0;
    r.kind = KIND_REPORT;
    // A zero full scale divides by one.
    fs = (shadow_cfg.axis_full_scale == 16'd0) ? 32'd1 : {16'd0, shadow_cfg.axis_full_scale};
    for (int i = 0; i < 4; i++) begin
      r.buttons[i] = ~pin_word[shadow_cfg.button_pins[5*i +: 5]];
      q = ({16'd0, axis_samples[i]} * {16'd0, AXIS_MAX}) / fs;
      if (q > {16'd0, AXIS_MAX})
        q = {16'd0, AXIS_MAX};
      scaled[i] = shadow_cfg.axis_invert[i] ? AXIS_MAX - q[15:0] : q[15:0];
    end
    r.axis_0 = scaled[0];
    r.axis_1 = scaled[1];
    r.axis_2 = scaled[2];
    r.axis_3 = scaled[3];
    return r;
  endfunction

  // Advances the shadow by one accepted command and queues what it should emit.
  task automatic sequence_step(input cmd_item_t it);
    res_item_t  staged [0:1];
    int         n;
    logic [2:0] nxt;
    n             = 0;
    cmd_effective = 1'b1;
    case (it.cmd)
      CMD_ALARM: begin
        if (bus_action(staged[0])) begin
          n              = 1;
          action_pending = 1'b1;
        end else begin
          cmd_effective = 1'b0;
        end
      end
      CMD_DONE: begin
        action_pending = 1'b0;
        case (poll_phase)
          PH_GPIO_REQ: begin
            if (it.write_acked)
              poll_phase = PH_GPIO_READ;
            staged[0] = alarm_schedule(DELAY_GPIO_REQ);
            n         = 1;
          end
          PH_GPIO_READ: begin
            pin_word   = it.read_data;
            poll_phase = PH_ADC_REQ;
            staged[0]  = alarm_schedule(DELAY_SHORT);
            n          = 1;
          end
          PH_ADC_REQ: begin
            if (it.write_acked)
              poll_phase = PH_ADC_READ;
            staged[0] = alarm_schedule(DELAY_ADC_REQ);
            n         = 1;
          end
          PH_ADC_READ: begin
            axis_samples[axis_idx] = it.read_data[15:0];
            nxt = {1'b0, axis_idx} + 3'd1;
            if (nxt >= AXIS_LIMIT) begin
              axis_idx   = 2'd0;
              poll_phase = PH_REST;
            end else if (shadow_cfg.axis_channels[5*nxt +: 5] == LANE_UNUSED) begin
              axis_idx   = 2'd0;
              poll_phase = PH_REST;
            end else begin
              axis_idx   = nxt[1:0];
              poll_phase = PH_ADC_REQ;
              staged[0]  = alarm_schedule(DELAY_SHORT);
              n          = 1;
            end
          end
          default: cmd_effective = 1'b0;
        endcase
      end
      CMD_UPDATE: begin
        if (poll_phase == PH_REST) begin
          staged[0]  = joystick_report();
          poll_phase = PH_GPIO_REQ;
          void'(bus_action(staged[1]));
          n              = 2;
          action_pending = 1'b1;
        end else begin
          cmd_effective = 1'b0;
        end
      end
      default: cmd_effective = 1'b0;
    endcase
    if (n > 0)
      staged[n-1].last = 1'b1;
    for (int k = 0; k < n; k++)
      awaited_actions.push_back(staged[k]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    res_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (awaited_actions.size() == 0) begin
        note_mismatch("result with nothing awaited, kind", 32'(res_item.kind), 32'd0);
      end else begin
        want = awaited_actions.pop_front();
        check_field("kind", 32'(res_item.kind), 32'(want.kind));
        check_field("last", 32'(res_item.last), 32'(want.last));
        check_field("bus_address", 32'(res_item.bus_address), 32'(want.bus_address));
        check_field("bus_module", 32'(res_item.bus_module), 32'(want.bus_module));
        check_field("bus_function", 32'(res_item.bus_function), 32'(want.bus_function));
        check_field("read_length", 32'(res_item.read_length), 32'(want.read_length));
        check_field("next_delay_us", 32'(res_item.next_delay_us),
                    32'(want.next_delay_us));
        check_field("buttons", 32'(res_item.buttons), 32'(want.buttons));
        check_field("axis_0", 32'(res_item.axis_0), 32'(want.axis_0));
        check_field("axis_1", 32'(res_item.axis_1), 32'(want.axis_1));
        check_field("axis_2", 32'(res_item.axis_2), 32'(want.axis_2));
        check_field("axis_3", 32'(res_item.axis_3), 32'(want.axis_3));
      end
    end
  end

  // The watchdog ends a run in which no transaction moves for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [1:0] cmd, input logic acked, input logic [31:0] data);
    cmd_item_t it;
    it.cmd         = cmd;
    it.write_acked = acked;
    it.read_data   = data;
    @(negedge clk);
    cmd_item  = it;
    cmd_valid = 1'b1;
    @(posedge clk);
    while (cmd_stall)
      @(posedge clk);
    sequence_step(it);
    // Valid stays high inside a burst; a burst ends with a random gap.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      cmd_valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic idle_cmd();
    @(negedge clk);
    cmd_valid = 1'b0;
  endtask

  task automatic drain_results();
    idle_cmd();
    while (awaited_actions.size() != 0)
      @(posedge clk);
  endtask

  // Commands that give no result may still be in flight after the last result.
  task automatic wait_quiet();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    case (idx)
      REG_BUTTON_PINS:   shadow_cfg.button_pins     = value[19:0];
      REG_AXIS_CHANNELS: shadow_cfg.axis_channels   = value[19:0];
      REG_FULL_SCALE:    shadow_cfg.axis_full_scale = value[15:0];
      REG_AXIS_INVERT:   shadow_cfg.axis_invert     = value[3:0];
      REG_DEVICE_ADDR:   shadow_cfg.device_address  = value[6:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apply_settings(input logic [19:0] pins, input logic [19:0] chans,
                                input logic [15:0] fs, input logic [3:0] inv,
                                input logic [6:0] addr);
    wait_quiet();
    write_reg(REG_BUTTON_PINS, {12'd0, pins});
    write_reg(REG_AXIS_CHANNELS, {12'd0, chans});
    write_reg(REG_FULL_SCALE, {16'd0, fs});
    write_reg(REG_AXIS_INVERT, {28'd0, inv});
    write_reg(REG_DEVICE_ADDR, {25'd0, addr});
  endtask

  // Mostly complete poll cycles with random data, with some stray commands mixed in.
  task automatic run_poll_traffic(input int count);
    int          handled;
    logic [1:0]  cmd;
    logic        acked;
    logic [31:0] data;
    handled = 0;
    while (handled < count) begin
      acked = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0:       data = '0;
        1:       data = '1;
        2:       data = $urandom_range(0, 255);
        default: data = $urandom;
      endcase
      if ($urandom_range(0, 7) == 0)
        cmd = 2'($urandom_range(CMD_ALARM, CMD_UNUSED));
      else if (poll_phase == PH_REST)
        cmd = CMD_UPDATE;
      else if (!action_pending)
        cmd = CMD_ALARM;
      else begin
        cmd   = CMD_DONE;
        acked = ($urandom_range(0, 6) != 0);
      end
      send_cmd(cmd, acked, data);
      if (cmd_effective)
        handled++;
      if ($urandom_range(0, 59) == 0)
        drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_poll_sequence();
    // Reset leaves the block waiting to read the pins, with every axis unused.
    send_cmd(CMD_UNUSED, 1'b1, '1);
    send_cmd(CMD_UPDATE, 1'b0, '0);
    send_cmd(CMD_ALARM, 1'b0, '0);
    send_cmd(CMD_DONE, 1'b0, 32'h0000_0000);
    // Axis 0 is sampled even though its lane marks it unused.
    send_cmd(CMD_ALARM, 1'b1, '0);
    send_cmd(CMD_DONE, 1'b0, '1);
    send_cmd(CMD_DONE, 1'b1, '0);
    send_cmd(CMD_ALARM, 1'b0, '1);
    send_cmd(CMD_DONE, 1'b0, 32'hFFFF_FFFF);
    // Resting: alarms and completions do nothing, then an update gives the report and a new poll cycle starts.
    send_cmd(CMD_ALARM, 1'b1, '1);
    send_cmd(CMD_DONE, 1'b1, '1);
    send_cmd(CMD_UPDATE, 1'b1, '1);
    send_cmd(CMD_DONE, 1'b0, '0);
    send_cmd(CMD_ALARM, 1'b0, '0);
    send_cmd(CMD_DONE, 1'b1, '0);
    send_cmd(CMD_ALARM, 1'b1, '0);
    send_cmd(CMD_DONE, 1'b0, 32'hFFFF_FFFF);
    // A zero full scale with every axis inverted.
    wait_quiet();
    write_reg(REG_FULL_SCALE, 32'd0);
    write_reg(REG_AXIS_INVERT, 32'hF);
    send_cmd(CMD_ALARM, 1'b0, '0);
    send_cmd(CMD_DONE, 1'b1, '0);
    send_cmd(CMD_ALARM, 1'b1, '1);
    send_cmd(CMD_DONE, 1'b1, 32'hFFFF_0000);
    send_cmd(CMD_UPDATE, 1'b0, '0);
  endtask

  task automatic test_extreme_settings();
    apply_settings(20'hFFFFF, 20'h00000, 16'hFFFF, 4'hF, 7'd127);
    run_poll_traffic(60);
    apply_settings(20'h00000, {LANE_UNUSED, LANE_UNUSED, LANE_UNUSED, 5'd0}, 16'd0, 4'h0,
                   7'd0);
    run_poll_traffic(60);
    apply_settings({5'd31, 5'd20, 5'd10, 5'd5}, {5'd7, LANE_UNUSED, 5'd1, 5'd30}, 16'd1, 4'h5,
                   7'h2A);
    run_poll_traffic(60);
  endtask

  task automatic test_random_settings();
    logic [19:0] chans;
    logic [15:0] fs;
    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 4; i++)
        chans[5*i +: 5] = ($urandom_range(0, 3) == 0) ? LANE_UNUSED : 5'($urandom_range(0, 30));
      case ($urandom_range(0, 3))
        0:       fs = 16'($urandom_range(1, 16));
        1:       fs = 16'($urandom_range(255, 4096));
        2:       fs = AXIS_MAX;
        default: fs = 16'($urandom_range(1, 65535));
      endcase
      apply_settings(20'($urandom_range(0, 20'hFFFFF)), chans, fs, 4'($urandom_range(0, 15)),
                     7'($urandom_range(0, 127)));
      run_poll_traffic(70);
    end
  endtask

  initial begin
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd_item   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    shadow_cfg.button_pins     = 20'h00000;
    shadow_cfg.axis_channels   = 20'hFFFFF;
    shadow_cfg.axis_full_scale = 16'd1;
    shadow_cfg.axis_invert     = 4'h0;
    shadow_cfg.device_address  = 7'h50;
    poll_phase     = PH_GPIO_READ;
    axis_idx       = 2'd0;
    pin_word       = 32'hFFFF_FFFF;
    action_pending = 1'b0;
    for (int i = 0; i < 4; i++)
      axis_samples[i] = SAMPLE_INIT;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_poll_sequence();
    test_extreme_settings();
    test_random_settings();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/gps_pkg.sv
hw/rtl/gps_cfg.sv
hw/rtl/gps_div.sv
hw/rtl/gamepad_poll_sequencer_core.sv
tb/tb_gamepad_poll_sequencer_core.sv
